/* src/lpv_pkg.sv */
package lpv_pkg;

    localparam int unsigned QBITS   = 16;
    localparam int unsigned PIX_W   = 16;
    localparam int unsigned XF_LAT  = 6;
    localparam int unsigned DIV_LAT = QBITS + 1;
    localparam int unsigned LAT     = XF_LAT + DIV_LAT + 1;

    typedef enum logic [2:0] {
        REG_ROT_X     = 3'd0,
        REG_ROT_Y     = 3'd1,
        REG_ROT_Z     = 3'd2,
        REG_CRAFT_POS = 3'd3,
        REG_SUN_DIR   = 3'd4,
        REG_SUN_MASK  = 3'd5,
        REG_FOCAL     = 3'd6,
        REG_SENSOR    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic pre_vis;
        logic neg_u;
        logic neg_v;
        logic zero_u;
        logic zero_v;
    } meta_t;

endpackage

/* src/landmark_pinhole_visibility_core.sv */
// each accepted item passes through the transform, the pixel dividers and the output register to its done strobe
// throughput: one item every cycle, busy never rises
// the depth is set by the 6-stage transform and the 17-stage pixel dividers
// results cannot be stalled; done is high for exactly one cycle per item
// async active-low reset clears the pipeline valid bits and restores the register defaults
module landmark_pinhole_visibility_core #(
    parameter int POS_BITS  = 21,
    parameter int UNIT_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               cfg_we,
    input  lpv_pkg::cfg_idx_t                  cfg_index,
    input  logic [((POS_BITS > UNIT_BITS) ? 3*POS_BITS : 3*UNIT_BITS)-1:0] cfg_data,
    input  logic signed [POS_BITS-1:0]         lmk_x,
    input  logic signed [POS_BITS-1:0]         lmk_y,
    input  logic signed [POS_BITS-1:0]         lmk_z,
    input  logic signed [UNIT_BITS-1:0]        norm_x,
    input  logic signed [UNIT_BITS-1:0]        norm_y,
    input  logic signed [UNIT_BITS-1:0]        norm_z,
    input  logic                               last_landmark,
    output logic                               done,
    output logic                               visible,
    output logic signed [lpv_pkg::PIX_W-1:0]   pixel_u,
    output logic signed [lpv_pkg::PIX_W-1:0]   pixel_v,
    output logic                               last_result
);

    localparam int CFG_W = (POS_BITS > UNIT_BITS) ? 3*POS_BITS : 3*UNIT_BITS;
    localparam int RW    = 3 * UNIT_BITS;
    localparam int CPW   = 3 * POS_BITS;
    localparam int CW    = POS_BITS + UNIT_BITS + 4;
    localparam int NW    = CW + 16;
    localparam int QB    = lpv_pkg::QBITS;
    localparam int PXW   = lpv_pkg::PIX_W;
    localparam int DL    = lpv_pkg::DIV_LAT;

    localparam logic [RW-1:0]        RX_RST = RW'(64'h0000_0000_0000_4000);
    localparam logic [RW-1:0]        RY_RST = RW'(64'h0000_0000_4000_0000);
    localparam logic [RW-1:0]        RZ_RST = RW'(64'h0000_4000_0000_0000);
    localparam logic [UNIT_BITS-1:0] MS_RST = UNIT_BITS'(64'hFFFF_FFFF_FFFF_C000);

    logic [RW-1:0]        rot_x_reg;
    logic [RW-1:0]        rot_y_reg;
    logic [RW-1:0]        rot_z_reg;
    logic [CPW-1:0]       craft_reg;
    logic [RW-1:0]        sun_reg;
    logic [UNIT_BITS-1:0] msine_reg;
    logic [15:0]          focal_reg;
    logic [31:0]          sensor_reg;
    logic [CFG_W-1:0]     cfg_lim;

    lpv_pkg::meta_t xf_meta;
    logic [NW-1:0]  num_u;
    logic [NW-1:0]  num_v;
    logic [CW-1:0]  den;

    logic           ovf_u;
    logic           ovf_v;
    logic [QB-1:0]  quo_u;
    logic [QB-1:0]  quo_v;
    logic           rnz_u;
    logic           rnz_v;

    lpv_pkg::meta_t meta_dly_reg [DL];
    lpv_pkg::meta_t mo;

    logic [QB:0]    qc_u;
    logic [QB:0]    qc_v;
    logic           inb_u;
    logic           inb_v;
    logic           vis;

    logic           done_reg;
    logic           visible_reg;
    logic [PXW-1:0] pixel_u_reg;
    logic [PXW-1:0] pixel_v_reg;
    logic           last_reg;
    logic [PXW-1:0] pixel_u_next;
    logic [PXW-1:0] pixel_v_next;

    // packed registers hold 64 bits at most
    always_comb
    begin
        for (int i = 0; i < CFG_W; i++)
            cfg_lim[i] = (i < 64) ? cfg_data[i] : 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_x_reg  <= RX_RST;
            rot_y_reg  <= RY_RST;
            rot_z_reg  <= RZ_RST;
            craft_reg  <= '0;
            sun_reg    <= RZ_RST;
            msine_reg  <= MS_RST;
            focal_reg  <= 16'd1000;
            sensor_reg <= 32'h0400_0400;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lpv_pkg::REG_ROT_X:     rot_x_reg  <= cfg_lim[RW-1:0];
                lpv_pkg::REG_ROT_Y:     rot_y_reg  <= cfg_lim[RW-1:0];
                lpv_pkg::REG_ROT_Z:     rot_z_reg  <= cfg_lim[RW-1:0];
                lpv_pkg::REG_CRAFT_POS: craft_reg  <= cfg_lim[CPW-1:0];
                lpv_pkg::REG_SUN_DIR:   sun_reg    <= cfg_lim[RW-1:0];
                lpv_pkg::REG_SUN_MASK:  msine_reg  <= cfg_lim[UNIT_BITS-1:0];
                lpv_pkg::REG_FOCAL:     focal_reg  <= cfg_lim[15:0];
                lpv_pkg::REG_SENSOR:    sensor_reg <= cfg_lim[31:0];
                default:                sensor_reg <= sensor_reg;
            endcase
        end
    end

    assign busy = 1'b0;

    lpv_xform #(
        .POS_BITS  (POS_BITS),
        .UNIT_BITS (UNIT_BITS)
    ) u_xform (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .in_last  (last_landmark),
        .lmk_x    (lmk_x),
        .lmk_y    (lmk_y),
        .lmk_z    (lmk_z),
        .nrm_x    (norm_x),
        .nrm_y    (norm_y),
        .nrm_z    (norm_z),
        .rot_x    (rot_x_reg),
        .rot_y    (rot_y_reg),
        .rot_z    (rot_z_reg),
        .craft    (craft_reg),
        .sun      (sun_reg),
        .msine    (msine_reg),
        .focal    (focal_reg),
        .meta     (xf_meta),
        .num_u    (num_u),
        .num_v    (num_v),
        .den      (den)
    );

    lpv_div #(
        .NW (NW),
        .ZW (CW)
    ) u_div_u (
        .clk    (clk),
        .num    (num_u),
        .den    (den),
        .ovf    (ovf_u),
        .quo    (quo_u),
        .rem_nz (rnz_u)
    );

    lpv_div #(
        .NW (NW),
        .ZW (CW)
    ) u_div_v (
        .clk    (clk),
        .num    (num_v),
        .den    (den),
        .ovf    (ovf_v),
        .quo    (quo_v),
        .rem_nz (rnz_v)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DL; i++)
                meta_dly_reg[i] <= '0;
        end
        else
        begin
            meta_dly_reg[0] <= xf_meta;
            for (int i = 1; i < DL; i++)
                meta_dly_reg[i] <= meta_dly_reg[i-1];
        end
    end

    // round away from zero, a zero quotient gives one
    always_comb
    begin
        mo    = meta_dly_reg[DL-1];
        qc_u  = mo.zero_u ? (QB+1)'(1) : (QB+1)'(quo_u) + (QB+1)'(rnz_u);
        qc_v  = mo.zero_v ? (QB+1)'(1) : (QB+1)'(quo_v) + (QB+1)'(rnz_v);
        inb_u = !ovf_u && ({qc_u, 1'b0} <= (QB+2)'(sensor_reg[15:0]));
        inb_v = !ovf_v && ({qc_v, 1'b0} <= (QB+2)'(sensor_reg[31:16]));
        vis   = mo.pre_vis && inb_u && inb_v;
        pixel_u_next = '0;
        pixel_v_next = '0;
        if (vis)
        begin
            pixel_u_next = mo.neg_u ? PXW'(-qc_u) : PXW'(qc_u);
            pixel_v_next = mo.neg_v ? PXW'(-qc_v) : PXW'(qc_v);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= 1'b0;
            visible_reg <= 1'b0;
            pixel_u_reg <= '0;
            pixel_v_reg <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            done_reg    <= mo.valid;
            visible_reg <= vis;
            pixel_u_reg <= pixel_u_next;
            pixel_v_reg <= pixel_v_next;
            last_reg    <= mo.last;
        end
    end

    assign done        = done_reg;
    assign visible     = visible_reg;
    assign pixel_u     = pixel_u_reg;
    assign pixel_v     = pixel_v_reg;
    assign last_result = last_reg;

endmodule

/* src/lpv_xform.sv */
module lpv_xform #(
    parameter int POS_BITS  = 21,
    parameter int UNIT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_last,
    input  logic signed [POS_BITS-1:0]    lmk_x,
    input  logic signed [POS_BITS-1:0]    lmk_y,
    input  logic signed [POS_BITS-1:0]    lmk_z,
    input  logic signed [UNIT_BITS-1:0]   nrm_x,
    input  logic signed [UNIT_BITS-1:0]   nrm_y,
    input  logic signed [UNIT_BITS-1:0]   nrm_z,
    input  logic [3*UNIT_BITS-1:0]        rot_x,
    input  logic [3*UNIT_BITS-1:0]        rot_y,
    input  logic [3*UNIT_BITS-1:0]        rot_z,
    input  logic [3*POS_BITS-1:0]         craft,
    input  logic [3*UNIT_BITS-1:0]        sun,
    input  logic signed [UNIT_BITS-1:0]   msine,
    input  logic [15:0]                   focal,
    output lpv_pkg::meta_t                meta,
    output logic [POS_BITS+UNIT_BITS+19:0] num_u,
    output logic [POS_BITS+UNIT_BITS+19:0] num_v,
    output logic [POS_BITS+UNIT_BITS+3:0] den
);

    localparam int U   = UNIT_BITS;
    localparam int DW  = POS_BITS + 1;
    localparam int PW  = DW + U;
    localparam int CW  = PW + 3;
    localparam int NW  = CW + 16;
    localparam int SW  = 2 * U + 2;
    localparam int LW  = 6 * U;

    logic signed [POS_BITS-1:0] lm [3];
    logic signed [POS_BITS-1:0] cp [3];
    logic signed [U-1:0]        nm [3];
    logic signed [U-1:0]        rx [3];
    logic signed [U-1:0]        ry [3];
    logic signed [U-1:0]        rz [3];
    logic signed [U-1:0]        sd [3];

    logic [5:1] vld_reg;
    logic [5:1] lst_reg;

    // stage 1
    logic signed [DW-1:0] d1_reg [3];
    logic signed [U-1:0]  n1_reg [3];
    // stage 2
    logic signed [PW-1:0]  px_reg [3];
    logic signed [PW-1:0]  py_reg [3];
    logic signed [PW-1:0]  pz_reg [3];
    logic signed [2*U-1:0] pn_reg [3];
    logic signed [2*U-1:0] pd_reg [3];
    logic signed [2*U-1:0] nn_reg [3];
    logic signed [2*U-1:0] ss_reg [3];
    // stage 3
    logic signed [CW-1:0] cx3_reg;
    logic signed [CW-1:0] cy3_reg;
    logic signed [CW-1:0] cz3_reg;
    logic signed [SW-1:0] nc3_reg;
    logic signed [SW-1:0] dot3_reg;
    logic [2*U-1:0]       n2_reg;
    logic [2*U-1:0]       s2_reg;
    // stage 4
    logic [CW-1:0]  ax4_reg;
    logic [CW-1:0]  ay4_reg;
    logic [CW-1:0]  z4_reg;
    logic [2*U-1:0] ad4_reg;
    logic [4*U-1:0] nsp4_reg;
    logic [2*U-1:0] mm4_reg;
    logic [7:0]     fl4_reg;
    // stage 5
    logic [NW-1:0]  nu5_reg;
    logic [NW-1:0]  nv5_reg;
    logic [CW-1:0]  z5_reg;
    logic [4*U-1:0] dsq5_reg;
    logic [4*U-1:0] rlo5_reg;
    logic [4*U-1:0] rhi5_reg;
    logic [7:0]     fl5_reg;
    // stage 6
    lpv_pkg::meta_t meta_reg;
    logic [NW-1:0]  nu6_reg;
    logic [NW-1:0]  nv6_reg;
    logic [CW-1:0]  z6_reg;

    logic [CW-1:0]  ax_next;
    logic [CW-1:0]  ay_next;
    logic [2*U-1:0] ad_next;
    logic [U-1:0]   am;
    logic [7:0]     fl_next;
    logic [LW-1:0]  lhs;
    logic [LW-1:0]  rhs;
    logic           lit;
    lpv_pkg::meta_t meta_next;

    // flag bits: 0 neg_x, 1 neg_y, 2 z positive, 3 normal faces camera,
    // 4 dot positive, 5 dot non-negative, 6 zero vector
    always_comb
    begin
        lm[0] = lmk_x;
        lm[1] = lmk_y;
        lm[2] = lmk_z;
        nm[0] = nrm_x;
        nm[1] = nrm_y;
        nm[2] = nrm_z;
        for (int i = 0; i < 3; i++)
        begin
            cp[i] = craft[i*POS_BITS +: POS_BITS];
            rx[i] = rot_x[i*U +: U];
            ry[i] = rot_y[i*U +: U];
            rz[i] = rot_z[i*U +: U];
            sd[i] = sun[i*U +: U];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            lst_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[4:1], in_valid};
            lst_reg <= {lst_reg[4:1], in_last};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            d1_reg[i] <= DW'(lm[i]) - DW'(cp[i]);
            n1_reg[i] <= nm[i];
            px_reg[i] <= PW'(rx[i]) * PW'(d1_reg[i]);
            py_reg[i] <= PW'(ry[i]) * PW'(d1_reg[i]);
            pz_reg[i] <= PW'(rz[i]) * PW'(d1_reg[i]);
            pn_reg[i] <= (2*U)'(rz[i]) * (2*U)'(n1_reg[i]);
            pd_reg[i] <= (2*U)'(sd[i]) * (2*U)'(n1_reg[i]);
            nn_reg[i] <= (2*U)'(n1_reg[i]) * (2*U)'(n1_reg[i]);
            ss_reg[i] <= (2*U)'(sd[i]) * (2*U)'(sd[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        cx3_reg  <= CW'(px_reg[0]) + CW'(px_reg[1]) + CW'(px_reg[2]);
        cy3_reg  <= CW'(py_reg[0]) + CW'(py_reg[1]) + CW'(py_reg[2]);
        cz3_reg  <= CW'(pz_reg[0]) + CW'(pz_reg[1]) + CW'(pz_reg[2]);
        nc3_reg  <= SW'(pn_reg[0]) + SW'(pn_reg[1]) + SW'(pn_reg[2]);
        dot3_reg <= SW'(pd_reg[0]) + SW'(pd_reg[1]) + SW'(pd_reg[2]);
        n2_reg   <= $unsigned(nn_reg[0]) + $unsigned(nn_reg[1]) + $unsigned(nn_reg[2]);
        s2_reg   <= $unsigned(ss_reg[0]) + $unsigned(ss_reg[1]) + $unsigned(ss_reg[2]);
    end

    always_comb
    begin
        ax_next = cx3_reg[CW-1] ? CW'(-cx3_reg) : CW'(cx3_reg);
        ay_next = cy3_reg[CW-1] ? CW'(-cy3_reg) : CW'(cy3_reg);
        ad_next = dot3_reg[SW-1] ? (2*U)'(-dot3_reg) : (2*U)'(dot3_reg);
        am      = msine[U-1] ? U'(-msine) : U'(msine);
        fl_next[0] = cx3_reg[CW-1];
        fl_next[1] = cy3_reg[CW-1];
        fl_next[2] = !cz3_reg[CW-1] && (cz3_reg != '0);
        fl_next[3] = nc3_reg[SW-1];
        fl_next[4] = !dot3_reg[SW-1] && (dot3_reg != '0);
        fl_next[5] = !dot3_reg[SW-1];
        fl_next[6] = (n2_reg == '0) || (s2_reg == '0);
        fl_next[7] = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        ax4_reg  <= ax_next;
        ay4_reg  <= ay_next;
        z4_reg   <= CW'(cz3_reg);
        ad4_reg  <= ad_next;
        nsp4_reg <= (4*U)'(n2_reg) * (4*U)'(s2_reg);
        mm4_reg  <= (2*U)'(am) * (2*U)'(am);
        fl4_reg  <= fl_next;
    end

    always_ff @(posedge clk)
    begin
        nu5_reg  <= NW'(focal) * NW'(ax4_reg);
        nv5_reg  <= NW'(focal) * NW'(ay4_reg);
        z5_reg   <= z4_reg;
        dsq5_reg <= (4*U)'(ad4_reg) * (4*U)'(ad4_reg);
        rlo5_reg <= (4*U)'(mm4_reg) * (4*U)'(nsp4_reg[2*U-1:0]);
        rhi5_reg <= (4*U)'(mm4_reg) * (4*U)'(nsp4_reg[4*U-1:2*U]);
        fl5_reg  <= fl4_reg;
    end

    // dot^2 * 2^(2f) against m^2 * |n|^2 * |s|^2
    always_comb
    begin
        lhs = LW'({dsq5_reg, {(2*U-4){1'b0}}});
        rhs = LW'(rlo5_reg) + (LW'(rhi5_reg) << (2*U));
        priority if (fl5_reg[6])
            lit = 1'b0;
        else if (msine == '0)
            lit = fl5_reg[4];
        else if (!msine[U-1])
            lit = fl5_reg[4] && (lhs > rhs);
        else
            lit = fl5_reg[5] || (lhs < rhs);
        meta_next.valid   = vld_reg[5];
        meta_next.last    = lst_reg[5];
        meta_next.pre_vis = fl5_reg[2] && fl5_reg[3] && lit;
        meta_next.neg_u   = fl5_reg[0];
        meta_next.neg_v   = fl5_reg[1];
        meta_next.zero_u  = (nu5_reg == '0);
        meta_next.zero_v  = (nv5_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            meta_reg <= '0;
        else
            meta_reg <= meta_next;
    end

    always_ff @(posedge clk)
    begin
        nu6_reg <= nu5_reg;
        nv6_reg <= nv5_reg;
        z6_reg  <= z5_reg;
    end

    assign meta  = meta_reg;
    assign num_u = nu6_reg;
    assign num_v = nv6_reg;
    assign den   = z6_reg;

endmodule

/* src/lpv_div.sv */
module lpv_div #(
    parameter int NW = 58,
    parameter int ZW = 42
) (
    input  logic                       clk,
    input  logic [NW-1:0]              num,
    input  logic [ZW-1:0]              den,
    output logic                       ovf,
    output logic [lpv_pkg::QBITS-1:0]  quo,
    output logic                       rem_nz
);

    localparam int QB = lpv_pkg::QBITS;

    logic [NW-1:0] rem_reg [QB+1];
    logic [ZW-1:0] den_reg [QB];
    logic [QB-1:0] quo_reg [QB+1];
    logic          ovf_reg [QB+1];

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num;
        den_reg[0] <= den;
        quo_reg[0] <= '0;
        ovf_reg[0] <= num >= (NW'(den) << QB);
    end

    // one quotient bit a stage, most significant first
    for (genvar j = 1; j <= QB; j++)
    begin : g_step
        logic [NW-1:0] sub;
        logic          ge;

        always_comb
        begin
            sub = NW'(den_reg[j-1]) << (QB - j);
            ge  = rem_reg[j-1] >= sub;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= ge ? rem_reg[j-1] - sub : rem_reg[j-1];
            quo_reg[j] <= {quo_reg[j-1][QB-2:0], ge};
            ovf_reg[j] <= ovf_reg[j-1];
        end

        if (j < QB)
        begin : g_den
            always_ff @(posedge clk)
            begin
                den_reg[j] <= den_reg[j-1];
            end
        end
    end

    assign ovf    = ovf_reg[QB];
    assign quo    = quo_reg[QB];
    assign rem_nz = (rem_reg[QB] != '0);

endmodule

/* src/lpv_checker.sv */
module lpv_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              last_landmark,
    input logic                              done,
    input logic                              visible,
    input logic signed [lpv_pkg::PIX_W-1:0]  pixel_u,
    input logic signed [lpv_pkg::PIX_W-1:0]  pixel_v,
    input logic                              last_result
);

    // every result traces back to an item taken a fixed time before
    a_done_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, lpv_pkg::LAT))
        else $error("result without an item");

    a_last_echo: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> last_result == $past(last_landmark, lpv_pkg::LAT))
        else $error("frame mark out of step");

    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !visible |-> pixel_u == '0 && pixel_v == '0)
        else $error("hidden landmark with pixel");

    a_visible_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && visible |-> pixel_u != '0 && pixel_v != '0)
        else $error("visible landmark with zero pixel");

endmodule

bind landmark_pinhole_visibility_core lpv_checker u_lpv_checker (.*);
